/* hdl/qrs_pkg.sv */
// Package for the quadratic root solver: port payload types and case codes.
// No dependencies; the top level uses it by scoped names.
`default_nettype none

package qrs_pkg;

  // Result case codes
  localparam logic [2:0] CaseLinear = 3'd0;
  localparam logic [2:0] CaseIndet  = 3'd1;
  localparam logic [2:0] CaseImposs = 3'd2;
  localparam logic [2:0] CaseNone   = 3'd3;
  localparam logic [2:0] CaseDouble = 3'd4;
  localparam logic [2:0] CaseTwo    = 3'd5;

  // Square root result bits (radicand below 2^66) and quotient bits
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps  = 32;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic [2:0]         case_code;
    logic signed [31:0] root_low;
    logic signed [31:0] root_high;
    logic               overflow;
  } result_t;

endpackage

`default_nettype wire

/* hdl/quadratic_root_solver.sv */
// Quadratic root solver: one fixed-point coefficient set in, case code and roots out.
// Depends on qrs_pkg for payload types and case codes.
// One set accepted every cycle; busy stays low.
// Path: input reg, two 32x32 products, discriminant, 33 square-root bit stages, numerator
// stage, divider load, 32 restoring-divide bit stages per root lane, saturation/output reg.
// The receiver cannot stall; asynchronous active-low reset clears all valid bits.
`default_nettype none

module quadratic_root_solver (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire qrs_pkg::coef_t  coef_i,
  output logic                 done_o,
  output qrs_pkg::result_t     result_o
);

  localparam int unsigned Ns = qrs_pkg::SqrtSteps;
  localparam int unsigned Nd = qrs_pkg::DivSteps;

  typedef struct packed {
    logic [2:0]         code;
    logic               a_neg;
    logic [31:0]        a_mag;
    logic signed [31:0] b_s;
    logic [31:0]        b_mag;
    logic [31:0]        c_mag;
    logic               lin_neg;
  } sq_ctl_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [31:0] d;
  } dv_ctl_t;

  assign busy = 1'b0;

  // ---------------- stage 1: input register
  logic          in_v_q;
  qrs_pkg::coef_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= coef_i;
  end

  // ---------------- stage 2: products
  logic [31:0] a_mag, b_mag, c_mag;
  assign a_mag = in_q.coef_a[31] ? 32'(-in_q.coef_a) : 32'(in_q.coef_a);
  assign b_mag = in_q.coef_b[31] ? 32'(-in_q.coef_b) : 32'(in_q.coef_b);
  assign c_mag = in_q.coef_c[31] ? 32'(-in_q.coef_c) : 32'(in_q.coef_c);

  logic               mul_v_q;
  logic [63:0]        bb_q, ac_q;
  logic               a_zero_q, b_zero_q, c_zero_q, a_neg_q, ac_neg_q, lin_neg_q;
  logic [31:0]        a_mag_q, b_mag_q, c_mag_q;
  logic signed [31:0] b_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else begin
      mul_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bb_q      <= b_mag * b_mag;
    ac_q      <= a_mag * c_mag;
    a_zero_q  <= (in_q.coef_a == '0);
    b_zero_q  <= (in_q.coef_b == '0);
    c_zero_q  <= (in_q.coef_c == '0);
    a_neg_q   <= in_q.coef_a[31];
    ac_neg_q  <= (in_q.coef_c != '0) && (in_q.coef_a[31] != in_q.coef_c[31]);
    lin_neg_q <= (in_q.coef_c != '0) && (in_q.coef_c[31] == in_q.coef_b[31]);
    a_mag_q   <= a_mag;
    b_mag_q   <= b_mag;
    c_mag_q   <= c_mag;
    b_s_q     <= in_q.coef_b;
  end

  // ---------------- stage 3: discriminant and case code
  logic [65:0] p4, bb66, disc;
  logic        neg_d;
  logic [2:0]  code_d;

  always_comb begin
    p4    = {ac_q, 2'b00};
    bb66  = {2'b00, bb_q};
    neg_d = 1'b0;
    disc  = '0;
    if (ac_neg_q) begin
      disc = bb66 + p4;
    end else if (p4 > bb66) begin
      neg_d = 1'b1;
    end else begin
      disc = bb66 - p4;
    end
    if (a_zero_q) begin
      disc = '0;
      if (!b_zero_q) begin
        code_d = qrs_pkg::CaseLinear;
      end else if (c_zero_q) begin
        code_d = qrs_pkg::CaseIndet;
      end else begin
        code_d = qrs_pkg::CaseImposs;
      end
    end else if (neg_d) begin
      code_d = qrs_pkg::CaseNone;
    end else if (disc == '0) begin
      code_d = qrs_pkg::CaseDouble;
    end else begin
      code_d = qrs_pkg::CaseTwo;
    end
  end

  logic          sq_v_q    [0:Ns];
  logic [65:0]   sq_rem_q  [0:Ns];
  logic [32:0]   sq_root_q [0:Ns];
  sq_ctl_t       sq_ctl_q  [0:Ns];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]         <= disc;
    sq_root_q[0]        <= '0;
    sq_ctl_q[0].code    <= code_d;
    sq_ctl_q[0].a_neg   <= a_neg_q;
    sq_ctl_q[0].a_mag   <= a_mag_q;
    sq_ctl_q[0].b_s     <= b_s_q;
    sq_ctl_q[0].b_mag   <= b_mag_q;
    sq_ctl_q[0].c_mag   <= c_mag_q;
    sq_ctl_q[0].lin_neg <= lin_neg_q;
  end

  // ---------------- square root, one result bit per stage, MSB first
  for (genvar k = 0; k < Ns; k++) begin : g_sqrt
    localparam int unsigned Bit = Ns - 1 - k;
    logic [65:0] trial;
    logic        take;

    assign trial = ({33'd0, sq_root_q[k]} << (Bit + 1)) | (66'd1 << (2 * Bit));
    assign take  = sq_rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_rem_q[k+1]  <= take ? sq_rem_q[k] - trial : sq_rem_q[k];
      sq_root_q[k+1] <= take ? (sq_root_q[k] | (33'd1 << Bit)) : sq_root_q[k];
      sq_ctl_q[k+1]  <= sq_ctl_q[k];
    end
  end

  // ---------------- numerator stage
  sq_ctl_t            sc;
  logic signed [34:0] nb, num_lo, num_hi;
  logic [34:0]        mag_lo, mag_hi;
  logic [49:0]        n_lo, n_hi;
  logic               neg_lo, neg_hi;
  logic [31:0]        den;

  assign sc = sq_ctl_q[Ns];

  always_comb begin
    nb     = -35'(sc.b_s);
    num_lo = nb - $signed({2'b00, sq_root_q[Ns]});
    num_hi = nb + $signed({2'b00, sq_root_q[Ns]});
    mag_lo = num_lo[34] ? 35'(-num_lo) : 35'(num_lo);
    mag_hi = num_hi[34] ? 35'(-num_hi) : 35'(num_hi);
    if (sc.code == qrs_pkg::CaseLinear) begin
      n_lo   = {2'b00, sc.c_mag, 16'd0};
      neg_lo = sc.lin_neg;
      den    = sc.b_mag;
    end else begin
      n_lo   = {mag_lo, 15'd0};
      neg_lo = num_lo[34] != sc.a_neg;
      den    = sc.a_mag;
    end
    n_hi   = {mag_hi, 15'd0};
    neg_hi = num_hi[34] != sc.a_neg;
  end

  logic        nm_v_q;
  logic [49:0] nm_n_q   [2];
  logic        nm_neg_q [2];
  dv_ctl_t     nm_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_v_q <= 1'b0;
    end else begin
      nm_v_q <= sq_v_q[Ns];
    end
  end

  always_ff @(posedge clk_i) begin
    nm_n_q[0]     <= n_lo;
    nm_n_q[1]     <= n_hi;
    nm_neg_q[0]   <= neg_lo;
    nm_neg_q[1]   <= neg_hi;
    nm_ctl_q.code <= sc.code;
    nm_ctl_q.d    <= den;
  end

  // ---------------- restoring division, one quotient bit per stage, two lanes
  logic        dv_v_q   [0:Nd];
  dv_ctl_t     dv_ctl_q [0:Nd];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= nm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_ctl_q[0] <= nm_ctl_q;
  end

  for (genvar k = 0; k < Nd; k++) begin : g_dv_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_ctl_q[k+1] <= dv_ctl_q[k];
    end
  end

  logic [31:0] quo   [2];
  logic        big   [2];
  logic        qneg  [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0] rem_q [0:Nd];
    logic [31:0] lo_q  [0:Nd];
    logic [31:0] q_q   [0:Nd];
    logic        big_q [0:Nd];
    logic        neg_q [0:Nd];

    // Quotient of 2^32 or more saturates regardless of sign
    always_ff @(posedge clk_i) begin
      big_q[0] <= {14'd0, nm_n_q[l][49:32]} >= nm_ctl_q.d;
      rem_q[0] <= {14'd0, nm_n_q[l][49:32]};
      lo_q[0]  <= nm_n_q[l][31:0];
      q_q[0]   <= '0;
      neg_q[0] <= nm_neg_q[l];
    end

    for (genvar k = 0; k < Nd; k++) begin : g_step
      logic [32:0] sh;
      logic        ge;

      assign sh = {rem_q[k], lo_q[k][31]};
      assign ge = sh >= {1'b0, dv_ctl_q[k].d};

      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= ge ? 32'(sh - {1'b0, dv_ctl_q[k].d}) : sh[31:0];
        lo_q[k+1]  <= {lo_q[k][30:0], 1'b0};
        q_q[k+1]   <= {q_q[k][30:0], ge};
        big_q[k+1] <= big_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end

    assign quo[l]  = q_q[Nd];
    assign big[l]  = big_q[Nd];
    assign qneg[l] = neg_q[Nd];
  end

  // ---------------- saturation and output register
  logic [31:0] root_v [2];
  logic        ovf_v  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!qneg[l]) begin
        ovf_v[l]  = big[l] || quo[l][31];
        root_v[l] = ovf_v[l] ? 32'h7FFF_FFFF : quo[l];
      end else begin
        ovf_v[l]  = big[l] || (quo[l] > 32'h8000_0000);
        root_v[l] = ovf_v[l] ? 32'h8000_0000 : 32'(-quo[l]);
      end
    end
  end

  qrs_pkg::result_t res_d, res_q;
  logic             out_v_q;

  always_comb begin
    res_d.case_code = dv_ctl_q[Nd].code;
    res_d.root_low  = '0;
    res_d.root_high = '0;
    res_d.overflow  = 1'b0;
    case (dv_ctl_q[Nd].code)
      qrs_pkg::CaseLinear, qrs_pkg::CaseDouble: begin
        res_d.root_low = root_v[0];
        res_d.overflow = ovf_v[0];
      end
      qrs_pkg::CaseTwo: begin
        res_d.root_low  = root_v[0];
        res_d.root_high = root_v[1];
        res_d.overflow  = ovf_v[0] || ovf_v[1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_v_q[Nd];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = out_v_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

/* tb/quadratic_root_solver_checker.sv */
`timescale 1ns / 1ps
// Checker for the quadratic root solver: predicts each root set on transfer
// and compares it with the next done_o result. Depends on qrs_pkg.
module quadratic_root_solver_checker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             busy_i,
  input  wire qrs_pkg::coef_t   coef_i,
  input  wire logic             done_i,
  input  wire qrs_pkg::result_t result_i,
  output int                    mismatches_o,
  output int                    pending_o
);
  import qrs_pkg::*;

  result_t roots_due[$];

  // Truncating division by magnitudes, saturated to Q16.16.
  function automatic logic [31:0] div_q16(logic [79:0] nmag, bit neg, logic [79:0] dmag,
                                          ref bit ovf);
    logic [79:0] q;
    if (dmag == 0) return 32'd0;
    q = nmag / dmag;
    if (!neg) begin
      if (q > 80'h7FFF_FFFF) begin
        ovf = 1'b1;
        q = 80'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 80'h8000_0000) begin
      ovf = 1'b1;
      q = 80'h8000_0000;
    end
    return 32'd0 - q[31:0];
  endfunction

  function automatic logic [79:0] mag(logic signed [79:0] x);
    return x < 0 ? -x : x;
  endfunction

  // root = num / (2a) in Q16.16
  function automatic logic [31:0] over_two_a(logic signed [79:0] num, logic signed [79:0] a,
                                             ref bit ovf);
    return div_q16(mag(num) << 15, (num < 0) != (a < 0), mag(a), ovf);
  endfunction

  function automatic result_t solve_roots(coef_t cf);
    logic signed [79:0] a, b, c, disc, s;
    logic [79:0] t, root;
    bit ovf;
    result_t r;
    a = cf.coef_a;
    b = cf.coef_b;
    c = cf.coef_c;
    ovf = 1'b0;
    r = '0;
    if (a == 0) begin
      if (b != 0) begin
        r.case_code = CaseLinear;
        r.root_low = div_q16(mag(c) << 16, c != 0 && ((c < 0) == (b < 0)), mag(b), ovf);
      end else begin
        r.case_code = (c == 0) ? CaseIndet : CaseImposs;
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        r.case_code = CaseNone;
      end else if (disc == 0) begin
        r.case_code = CaseDouble;
        r.root_low = over_two_a(-b, a, ovf);
      end else begin
        root = '0;
        for (int i = 34; i >= 0; i--) begin
          t = root | (80'd1 << i);
          if (t * t <= disc) root = t;
        end
        s = root;
        r.case_code = CaseTwo;
        r.root_low = over_two_a(-b - s, a, ovf);
        r.root_high = over_two_a(-b + s, a, ovf);
      end
    end
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h, want %h", $realtime, field, got, want);
    mismatches_o++;
  endtask

  initial mismatches_o = 0;
  assign pending_o = roots_due.size();

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) roots_due.push_back(solve_roots(coef_i));
      if (done_i) begin
        if (roots_due.size() == 0) begin
          $display("%0t: result with none outstanding", $realtime);
          mismatches_o++;
        end else begin
          want = roots_due.pop_front();
          if (result_i.case_code !== want.case_code)
            report("case_code", result_i.case_code, want.case_code);
          if (result_i.root_low !== want.root_low)
            report("root_low", result_i.root_low, want.root_low);
          if (result_i.root_high !== want.root_high)
            report("root_high", result_i.root_high, want.root_high);
          if (result_i.overflow !== want.overflow)
            report("overflow", result_i.overflow, want.overflow);
        end
      end
    end
  end
endmodule

/* tb/quadratic_root_solver_test.sv */
`timescale 1ns / 1ps
// Testbench top for the quadratic root solver: directed and random coefficient
// sets with random gaps. Depends on qrs_pkg, the solver and its checker.
module quadratic_root_solver_test;
  import qrs_pkg::*;

  localparam int RandomSets = 1900;
  localparam int SteadyTail = 300;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 100;

  logic clk_i, rst_ni, start, busy, done_o;
  coef_t coef_i;
  result_t result_o;
  int mismatches, pending, quiet_cycles;

  quadratic_root_solver uut (.*);

  quadratic_root_solver_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .coef_i, .done_i(done_o),
    .result_i(result_o), .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hold the stream and drive one set; return once it transfers.
  task automatic send_set(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    bit was_busy;
    start <= 1'b1;
    coef_i <= '{coef_a: a, coef_b: b, coef_c: c};
    do begin
      @(negedge clk_i) was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
  endtask

  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      3: return $signed($urandom_range(0, 64)) - 32;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  // Watchdog: stop when neither side transfers for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int p, q, pick;
    logic [31:0] a, b, c;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    coef_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each case code, extremes and saturation.
    send_set(0, 2 << 16, 3 << 16);
    send_set(0, -(3 << 16), 7 << 16);
    send_set(0, 1, 32'h7FFF_FFFF);
    send_set(0, 1, 32'h8000_0000);
    send_set(0, 0, 0);
    send_set(0, 0, 5);
    send_set(1 << 16, 0, 1 << 16);
    send_set(1 << 16, 2 << 16, 1 << 16);
    send_set(-(1 << 16), 4 << 16, -(4 << 16));
    send_set(1 << 16, -(3 << 16), 2 << 16);
    send_set(-(1 << 16), 1 << 16, 6 << 16);
    send_set(1, 32'h7FFF_FFFF, 0);
    send_set(1, 32'h8000_0000, 0);
    send_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_set(32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_set(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_set(32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_set(-1, 0, 0);
    send_set(1, 0, 0);

    for (int n = 0; n < RandomSets; n++) begin
      maybe_idle(n < RandomSets - SteadyTail);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Zero discriminant: b = 2pq, c = p q^2
        p = $signed($urandom_range(1, 2000)) * ($urandom_range(0, 1) ? 1 : -1);
        q = $signed($urandom_range(0, 2000)) - 1000;
        a = p;
        b = 2 * p * q;
        c = p * q * q;
      end else if (pick == 1) begin
        a = 0;
        b = $urandom_range(0, 3) == 0 ? 0 : pick_coef();
        c = $urandom_range(0, 3) == 0 ? 0 : pick_coef();
      end else begin
        a = pick_coef();
        b = pick_coef();
        c = pick_coef();
      end
      send_set(a, b, c);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
